### src/sync_length_checksum_frame_parser_assert.svh
// assertion macros for the frame parser checker
`ifndef SYNC_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define SLCFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define SLCFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/slcfp_pkg.sv
`default_nettype none

package slcfp_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'hAA;

   localparam logic [1:0] KIND_CMD     = 2'd0;
   localparam logic [1:0] KIND_LEN     = 2'd1;
   localparam logic [1:0] KIND_DATA    = 2'd2;
   localparam logic [1:0] KIND_VERDICT = 2'd3;

   localparam logic [8:0] POS_CMD       = 9'd0;
   localparam logic [8:0] POS_LEN       = 9'd1;
   localparam logic [8:0] POS_DATA_BASE = 9'd2;
   localparam logic [8:0] POS_MAX       = 9'd256;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic [8:0] position;
      logic       checksum_ok;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } result_type;

endpackage

`default_nettype wire

### src/slcfp_if.sv
`default_nettype none

interface slcfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;
   logic [8:0] position;
   logic       checksum_ok;

   modport source (output valid, output kind, output value, output position,
                   output checksum_ok, input ready);
   modport sink (input valid, input kind, input value, input position,
                 input checksum_ok, output ready);
endinterface

`default_nettype wire

### src/slcfp_in_stage.sv
`default_nettype none

module slcfp_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   slcfp_req_if.sink       req,
   input  wire logic       advance,
   output      logic       byte_valid,
   output      logic [7:0] rx_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req.rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign rx_byte    = byte_ff;

endmodule

`default_nettype wire

### src/slcfp_parser.sv
`default_nettype none

module slcfp_parser
   import slcfp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] rx_byte,
   output      result_type result
);

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_CMD   = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_CSUM  = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] count_next;
   logic [8:0] position;

   assign count_next = count_ff + 8'd1;
   assign position   = POS_DATA_BASE + {1'b0, count_ff};

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      result    = '0;
      if (fire) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == SYNC_FIRST) begin
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               phase_in = (rx_byte == SYNC_SECOND) ? PH_CMD : PH_HUNT;
            end
            PH_CMD: begin
               sum_in      = rx_byte;
               phase_in    = PH_LEN;
               result.valid = 1'b1;
               result.item  = '{kind: KIND_CMD, value: rx_byte, position: POS_CMD,
                                checksum_ok: 1'b0};
            end
            PH_LEN: begin
               length_in    = rx_byte;
               count_in     = 8'd0;
               sum_in       = sum_ff + rx_byte;
               phase_in     = (rx_byte <= 8'd1) ? PH_CSUM : PH_DATA;
               result.valid = 1'b1;
               result.item  = '{kind: KIND_LEN, value: rx_byte, position: POS_LEN,
                                checksum_ok: 1'b0};
            end
            PH_DATA: begin
               sum_in   = sum_ff + rx_byte;
               count_in = count_next;
               if (({1'b0, count_next} + 9'd1) >= {1'b0, length_ff}) begin
                  phase_in = PH_CSUM;
               end
               result.valid = 1'b1;
               result.item  = '{kind: KIND_DATA, value: rx_byte, position: position,
                                checksum_ok: 1'b0};
            end
            PH_CSUM: begin
               phase_in     = PH_HUNT;
               result.valid = 1'b1;
               result.item  = '{kind: KIND_VERDICT, value: rx_byte, position: position,
                                checksum_ok: (sum_ff == rx_byte)};
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         length_ff <= 8'd0;
         count_ff  <= 8'd0;
         sum_ff    <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

`default_nettype wire

### src/slcfp_out_stage.sv
`default_nettype none

module slcfp_out_stage
   import slcfp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire result_type result,
   output      logic       advance,
   slcfp_rsp_if.source     rsp
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign advance  = !valid_ff || rsp.ready;
   assign valid_in = advance ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         item_ff <= result.item;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = item_ff.kind;
   assign rsp.value       = item_ff.value;
   assign rsp.position    = item_ff.position;
   assign rsp.checksum_ok = item_ff.checksum_ok;

endmodule

`default_nettype wire

### src/sync_length_checksum_frame_parser.sv
// frame parser for a received serial byte stream
// req_ch carries one received byte per request (rx_byte); rsp_ch carries the
// results: command, length and data bytes tagged with their frame position,
// and for the checksum byte a verdict with checksum_ok set when the 8-bit sum
// of command, length and data bytes matches
// sync bytes (0x55 then 0xaa) and bytes outside a frame give no result
// each request taken is held in the input register, then parsed into the
// result register, which drives rsp_ch
// throughput: one byte per cycle while rsp_ready is high, set by the
// combinational parse between the two registers; the running sum stands in
// for a sum over the frame
// when rsp_ready is low the result register holds and one more request is
// taken into the input register, after which req_ready follows rsp_ready
// reset (synchronous, active high) empties both registers and sends the
// parser back to hunting for the first sync byte
`default_nettype none

module sync_length_checksum_frame_parser
   import slcfp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   slcfp_req_if.sink   req_ch,
   slcfp_rsp_if.source rsp_ch
);

   logic       advance;
   logic       byte_valid;
   logic [7:0] rx_byte;
   result_type result;

   slcfp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .advance    (advance),
      .byte_valid (byte_valid),
      .rx_byte    (rx_byte)
   );

   slcfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (byte_valid && advance),
      .rx_byte (rx_byte),
      .result  (result)
   );

   slcfp_out_stage u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .result  (result),
      .advance (advance),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire

### src/slcfp_checker.sv
`default_nettype none
`include "sync_length_checksum_frame_parser_assert.svh"

module slcfp_checker
   import slcfp_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_value,
   input wire logic [8:0] rsp_position,
   input wire logic       rsp_checksum_ok
);

   // stalled result holds
   `SLCFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_value) && $stable(rsp_position) && $stable(rsp_checksum_ok), "stalled result changed")

   `SLCFP_ASSERT_NOW(a_ok_only_verdict, clock, reset, rsp_valid && (rsp_kind != KIND_VERDICT), !rsp_checksum_ok, "checksum flag set outside a verdict")

   `SLCFP_ASSERT_NOW(a_header_pos, clock, reset, rsp_valid && (rsp_kind == KIND_CMD || rsp_kind == KIND_LEN), rsp_position == ((rsp_kind == KIND_CMD) ? POS_CMD : POS_LEN), "header byte at wrong position")

   `SLCFP_ASSERT_NOW(a_body_pos, clock, reset, rsp_valid && (rsp_kind == KIND_DATA || rsp_kind == KIND_VERDICT), rsp_position >= POS_DATA_BASE && rsp_position <= POS_MAX, "body byte position out of range")

endmodule

bind sync_length_checksum_frame_parser slcfp_checker u_slcfp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_kind        (rsp_ch.kind),
   .rsp_value       (rsp_ch.value),
   .rsp_position    (rsp_ch.position),
   .rsp_checksum_ok (rsp_ch.checksum_ok)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import slcfp_pkg::*;

   typedef enum logic [2:0] {
      ST_HUNT, ST_SYNC2, ST_CMD, ST_LEN, ST_DATA, ST_CSUM
   } parse_state_type;

   logic clock = 1'b0;
   logic reset;

   slcfp_req_if req_ch ();
   slcfp_rsp_if rsp_ch ();

   sync_length_checksum_frame_parser i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [7:0]   pending_bytes[$];
   rsp_item_type expected_results[$];

   parse_state_type model_state;
   logic [7:0]      model_length;
   logic [7:0]      model_count;
   logic [7:0]      model_sum;

   int idle_pct;
   int stall_pct;
   int hold_left;
   int bytes_queued;
   int bytes_sent;
   int results_seen;
   int verdicts_ok;
   int verdicts_bad;
   int failures;
   int longest_frame;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // expected result for one received byte, advancing the parse state
   function automatic bit parse_byte(input logic [7:0] b, output rsp_item_type r);
      bit produced;
      produced = 1'b0;
      r = '0;
      case (model_state)
         ST_HUNT: begin
            if (b == SYNC_FIRST) model_state = ST_SYNC2;
         end
         ST_SYNC2: begin
            model_state = (b == SYNC_SECOND) ? ST_CMD : ST_HUNT;
         end
         ST_CMD: begin
            model_sum = b;
            model_state = ST_LEN;
            r.kind = KIND_CMD;
            r.value = b;
            r.position = POS_CMD;
            produced = 1'b1;
         end
         ST_LEN: begin
            model_length = b;
            model_count = 8'd0;
            model_sum = model_sum + b;
            model_state = (b <= 8'd1) ? ST_CSUM : ST_DATA;
            r.kind = KIND_LEN;
            r.value = b;
            r.position = POS_LEN;
            produced = 1'b1;
         end
         ST_DATA: begin
            r.kind = KIND_DATA;
            r.value = b;
            r.position = POS_DATA_BASE + {1'b0, model_count};
            model_sum = model_sum + b;
            model_count = model_count + 8'd1;
            if ({1'b0, model_count} + 9'd1 >= {1'b0, model_length}) model_state = ST_CSUM;
            produced = 1'b1;
         end
         ST_CSUM: begin
            r.kind = KIND_VERDICT;
            r.value = b;
            r.position = POS_DATA_BASE + {1'b0, model_count};
            r.checksum_ok = (model_sum == b);
            model_state = ST_HUNT;
            produced = 1'b1;
         end
         default: begin
            model_state = ST_HUNT;
         end
      endcase
      return produced;
   endfunction

   // driver: one request per handshake, fed from the pending queue
   always @(posedge clock) begin
      rsp_item_type r;
      if (reset) begin
         req_ch.valid <= 1'b0;
         model_state = ST_HUNT;
         model_length = 8'd0;
         model_count = 8'd0;
         model_sum = 8'd0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            bytes_sent++;
            if (parse_byte(req_ch.rx_byte, r)) expected_results.push_back(r);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.rx_byte <= pending_bytes.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("unexpected result: kind %0d value %02h position %0d ok %0b",
                        rsp_ch.kind, rsp_ch.value, rsp_ch.position, rsp_ch.checksum_ok);
            end
         end else begin
            want = expected_results.pop_front();
            if (want.kind == KIND_VERDICT) begin
               if (want.checksum_ok) verdicts_ok++;
               else verdicts_bad++;
            end
            if (rsp_ch.kind !== want.kind || rsp_ch.value !== want.value ||
                rsp_ch.position !== want.position ||
                rsp_ch.checksum_ok !== want.checksum_ok) begin
               failures++;
               if (failures <= 10) begin
                  $display("mismatch on result %0d: expected kind %0d value %02h pos %0d ok %0b",
                           results_seen, want.kind, want.value, want.position,
                           want.checksum_ok);
                  $display("   got kind %0d value %02h pos %0d ok %0b",
                           rsp_ch.kind, rsp_ch.value, rsp_ch.position, rsp_ch.checksum_ok);
               end
            end
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_frame(input int len, input bit good);
      logic [7:0] b;
      logic [7:0] sum;
      push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      b = 8'($urandom);
      sum = b;
      push_byte(b);
      push_byte(len[7:0]);
      sum = sum + len[7:0];
      for (int i = 0; i < len - 1; i++) begin
         b = 8'($urandom);
         sum = sum + b;
         push_byte(b);
      end
      if (!good) sum = sum ^ 8'($urandom_range(1, 255));
      push_byte(sum);
      if (len > longest_frame) longest_frame = len;
   endtask

   // mostly well-formed frames, with noise, bad sync and cut-short frames mixed in
   task automatic run_phase(input int idle, input int stall, input int items,
                            input int big_len, input int hold);
      int start;
      int pick;
      int n;
      logic [7:0] b;
      @(negedge clock);
      idle_pct = idle;
      stall_pct = stall;
      start = bytes_queued;
      if (big_len > 0) queue_frame(big_len, 1'($urandom_range(1)));
      while (bytes_queued - start < items) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            if ($urandom_range(99) < 92) n = $urandom_range(0, 10);
            else n = $urandom_range(11, 60);
            queue_frame(n, $urandom_range(99) < 75);
         end else if (pick < 80) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               b = ($urandom_range(3) == 0) ? SYNC_SECOND : 8'($urandom);
               push_byte(b);
            end
         end else if (pick < 90) begin
            push_byte(SYNC_FIRST);
            if ($urandom_range(1)) begin
               b = SYNC_FIRST;
            end else begin
               do b = 8'($urandom); while (b == SYNC_SECOND);
            end
            push_byte(b);
         end else begin
            push_byte(SYNC_FIRST);
            push_byte(SYNC_SECOND);
            push_byte(8'($urandom));
            push_byte(8'($urandom_range(2, 20)));
            n = $urandom_range(0, 3);
            repeat (n) push_byte(8'($urandom));
         end
      end
      if (hold > 0) hold_left = hold;
      while (pending_bytes.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [7:0] directed [23];
      int waited;
      directed = '{
         8'h00, 8'hFF,
         8'h55, 8'h55,
         8'h55, 8'h00,
         8'h55, 8'hAA, 8'h00, 8'h00, 8'h00,
         8'h55, 8'hAA, 8'hFF, 8'h01, 8'h7F,
         8'h55, 8'hAA, 8'h12, 8'h03, 8'hFF, 8'h00, 8'h14
      };
      req_ch.valid = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      reset = 1'b1;
      foreach (directed[i]) push_byte(directed[i]);
      longest_frame = 3;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      run_phase(0, 0, 455, 0, 300);
      run_phase(45, 0, 455, 255, 0);
      run_phase(0, 45, 455, 0, 0);
      run_phase(16, 16, 455, 254, 0);

      while (req_ch.valid) @(negedge clock);
      stall_pct = 0;
      waited = 0;
      while (expected_results.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      if (expected_results.size() != 0) begin
         $display("%0d expected results never arrived", expected_results.size());
         failures += expected_results.size();
      end

      $display("sent %0d bytes, checked %0d results, longest frame length %0d",
               bytes_sent, results_seen, longest_frame);
      $display("verdicts: %0d good checksum, %0d bad; %0d failures",
               verdicts_ok, verdicts_bad, failures);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d bytes still pending", pending_bytes.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
